/* rtl/mrpt_pkg.sv */
// shared types and constants for the primality test core
`default_nettype none
package mrpt_pkg;
    localparam int unsigned WIT_TABLE_SIZE = 12;
    localparam int unsigned WIT_BITS = 6;
    localparam int unsigned WIT_IDX_BITS = 4;

    function automatic logic [WIT_BITS-1:0] witness(input logic [WIT_IDX_BITS-1:0] idx);
        logic [WIT_BITS-1:0] w;
        begin
            case (idx)
                4'd0: w = 6'd2;
                4'd1: w = 6'd3;
                4'd2: w = 6'd5;
                4'd3: w = 6'd7;
                4'd4: w = 6'd11;
                4'd5: w = 6'd13;
                4'd6: w = 6'd17;
                4'd7: w = 6'd19;
                4'd8: w = 6'd23;
                4'd9: w = 6'd29;
                4'd10: w = 6'd31;
                4'd11: w = 6'd37;
                default: w = 6'd37;
            endcase
            return w;
        end
    endfunction

    typedef enum logic [3:0] {
        T_IDLE, T_BASE, T_POW_SQ, T_POW_MUL, T_CHAIN, T_CHECK, T_DONE
    } t_be_state;

    typedef enum logic [1:0] {
        T_CLS_RUN, T_CLS_PRIME, T_CLS_COMP
    } t_class;
endpackage
`default_nettype wire

/* rtl/mrpt_mulmod.sv */
// iterative double-and-add modular multiplier, one multiplier bit per cycle
`default_nettype none
module mrpt_mulmod
    import mrpt_pkg::*;
#(
    parameter int unsigned W = 63
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_m,
    output logic              o_busy,
    output logic              o_done,
    output logic [W-1:0]      o_p
);
    logic [W-1:0] r_acc, r_a, r_b, r_m;
    logic         r_busy, r_done;
    logic [W:0]   sum_acc, sum_dbl;
    logic [W-1:0] n_acc, n_a;

    assign sum_acc = {1'b0, r_acc} + {1'b0, r_a};
    assign sum_dbl = {r_a, 1'b0};
    always_comb begin
        n_acc = r_acc;
        if (r_b[0]) begin
            n_acc = (sum_acc >= {1'b0, r_m}) ? W'(sum_acc - {1'b0, r_m}) : sum_acc[W-1:0];
        end
        n_a = (sum_dbl >= {1'b0, r_m}) ? W'(sum_dbl - {1'b0, r_m}) : sum_dbl[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_b == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
        end else if (r_busy && r_b != '0) begin
            r_acc <= n_acc;
            r_a   <= n_a;
            r_b   <= r_b >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule
`default_nettype wire

/* rtl/mrpt_front.sv */
// front end: takes candidates, settles trivial ones, queues every word with its class
`default_nettype none
module mrpt_front
    import mrpt_pkg::*;
#(
    parameter int unsigned W = 63
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_candidate,
    output logic              o_busy,
    output logic              o_q_valid,
    output logic [W-1:0]      o_q_n,
    output t_class            o_q_cls,
    input  wire logic         i_q_pop
);
    // two-entry queue
    logic [W-1:0] r_n [2];
    t_class       r_c [2];
    logic [1:0]   r_cnt;
    logic         r_wp, r_rp;
    logic         push;
    t_class       cls;

    // small candidates: prime iff equal to some base below 38
    always_comb begin
        cls = T_CLS_RUN;
        if (i_candidate < W'(38)) begin
            cls = T_CLS_COMP;
            for (int i = 0; i < WIT_TABLE_SIZE; i++) begin
                if (i_candidate == W'(witness(WIT_IDX_BITS'(i)))) cls = T_CLS_PRIME;
            end
        end
    end

    assign o_busy = (r_cnt == 2'd2);
    assign push   = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_n[r_wp] <= i_candidate;
            r_c[r_wp] <= cls;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_n     = r_n[r_rp];
    assign o_q_cls   = r_c[r_rp];
endmodule
`default_nettype wire

/* rtl/mrpt_back.sv */
// back end: witness loop over modular exponentiation and squaring chain
`default_nettype none
module mrpt_back
    import mrpt_pkg::*;
#(
    parameter int unsigned W = 63,
    parameter int unsigned NUM_WITNESSES = 12
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_valid,
    input  wire logic [W-1:0] i_q_n,
    input  wire t_class       i_q_cls,
    output logic              o_q_pop,
    output logic              o_valid,
    output logic              o_is_prime
);
    localparam int unsigned SB = $clog2(W + 1);
    t_be_state r_st, n_st;
    logic [W-1:0] r_n, r_odd, r_e, r_acc, r_b, r_x;
    logic [SB-1:0] r_s, r_k;
    logic [WIT_IDX_BITS-1:0] r_wi;
    logic r_mdone_seen, r_ok, r_seen_m1;
    logic r_valid, r_prime;
    logic mul_start, mul_busy, mul_done;
    logic [W-1:0] ma, mb, mp;
    logic [W-1:0] nm1;
    logic [W-1:0] wb;
    logic last_w;
    logic base_ok;

    assign nm1 = r_n - W'(1);
    assign wb  = W'(witness(r_wi));
    assign last_w = (32'(r_wi) + 1 >= NUM_WITNESSES) || (32'(r_wi) + 1 >= WIT_TABLE_SIZE);
    // current base passes: chain bottom is 1 and, if any squaring happens, b^odd is 1 or n-1 comes before the bottom
    assign base_ok = r_ok && ((r_s != '0) ? r_seen_m1 : (r_x == W'(1)));

    mrpt_mulmod #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(ma), .i_b(mb), .i_m(r_n), .o_busy(mul_busy), .o_done(mul_done), .o_p(mp)
    );

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            T_IDLE: if (i_q_valid) n_st = (i_q_cls == T_CLS_RUN) ? T_BASE : T_DONE;
            T_BASE: n_st = (r_odd[0] == 1'b0 && r_odd != '0) ? T_BASE : T_POW_MUL;
            T_POW_MUL: if (r_mdone_seen) n_st = T_POW_SQ;
            T_POW_SQ: if (r_mdone_seen) n_st = (r_e == '0) ? T_CHAIN : T_POW_MUL;
            T_CHAIN: if (r_mdone_seen && r_k == '0) n_st = T_CHECK;
            T_CHECK: n_st = (!base_ok || last_w) ? T_DONE : T_BASE;
            T_DONE: n_st = T_IDLE;
            default: n_st = T_IDLE;
        endcase
    end

    // multiplier operands and start
    always_comb begin
        mul_start = 1'b0;
        ma = r_acc;
        mb = r_b;
        case (r_st)
            T_POW_MUL: begin
                ma = r_acc; mb = r_b;
                mul_start = r_e[0] && !mul_busy && !mul_done && !r_mdone_seen;
            end
            T_POW_SQ: begin
                ma = r_b; mb = r_b;
                mul_start = !mul_busy && !mul_done && !r_mdone_seen && r_e != '0;
            end
            T_CHAIN: begin
                ma = r_x; mb = r_x;
                mul_start = (r_k != '0) && !mul_busy && !mul_done && !r_mdone_seen;
            end
            default: mul_start = 1'b0;
        endcase
    end

    assign o_q_pop = (r_st == T_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= T_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_valid <= (r_st == T_DONE);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_mdone_seen <= 1'b0;
        case (r_st)
            T_IDLE: begin
                r_n   <= i_q_n;
                r_wi  <= '0;
                r_prime <= (i_q_cls == T_CLS_PRIME);
                r_ok  <= 1'b1;
                r_odd <= i_q_n - W'(1);
                r_s   <= '0;
            end
            T_BASE: begin
                // odd part found once per candidate; reuse after first base
                if (r_odd[0] == 1'b0 && r_odd != '0) begin
                    r_odd <= r_odd >> 1;
                    r_s   <= r_s + SB'(1);
                end else begin
                    r_e   <= r_odd;
                    r_acc <= W'(1);
                    r_b   <= wb;
                end
            end
            T_POW_MUL: begin
                if (!r_e[0] && !r_mdone_seen) r_mdone_seen <= 1'b1;
                if (mul_done) begin r_acc <= mp; r_mdone_seen <= 1'b1; end
                if (r_mdone_seen) r_e <= r_e >> 1;
            end
            T_POW_SQ: begin
                if (r_e == '0) begin
                    r_mdone_seen <= 1'b1;
                    r_x  <= r_acc;
                    r_k  <= r_s;
                    r_seen_m1 <= (r_acc == W'(1)) || (r_acc == nm1);
                end
                if (mul_done) begin r_b <= mp; r_mdone_seen <= 1'b1; end
            end
            T_CHAIN: begin
                // squares downward: x = b^(odd*2^j); pass if 1 at top, or n-1 before end
                if (r_k == '0) r_mdone_seen <= 1'b1;
                if (mul_done) begin
                    r_x <= mp;
                    r_k <= r_k - SB'(1);
                    if (mp == nm1 && r_k != SB'(1)) r_seen_m1 <= 1'b1;
                    if (r_k == SB'(1) && mp != W'(1)) r_ok <= 1'b0;
                    if (mp == nm1 && r_k == SB'(1)) r_ok <= 1'b0;
                end
            end
            T_CHECK: begin
                r_ok <= base_ok;
                r_wi <= r_wi + WIT_IDX_BITS'(1);
                r_prime <= base_ok;
            end
            default: ;
        endcase
    end

    assign o_valid    = r_valid;
    assign o_is_prime = r_prime;
endmodule
`default_nettype wire

/* rtl/miller_rabin_prime_test_core.sv */
// top level of the deterministic miller-rabin primality tester
// candidates below 38 are settled in the front end; the rest run through up to 12
// witness bases, each a modular exponentiation and a squaring chain on the multiplier
// throughput: one word at a time in the back end, set by the bit-serial multiplier
// a two-word queue lets start be taken while the back end works; receiver cannot stall
// reset: synchronous active-low i_rst_n empties the queue and idles the back end
`default_nettype none
module miller_rabin_prime_test_core
    import mrpt_pkg::*;
#(
    parameter int unsigned NUM_WITNESSES = 12,
    parameter int unsigned VALUE_BITS = 63
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [VALUE_BITS-1:0] i_candidate,
    output logic                       o_valid,
    output logic                       o_is_prime
);
    logic              q_valid, q_pop;
    logic [VALUE_BITS-1:0] q_n;
    t_class            q_cls;

    // front: classify small words, queue every word with its class
    mrpt_front #(.W(VALUE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_candidate(i_candidate),
        .o_busy(busy), .o_q_valid(q_valid), .o_q_n(q_n), .o_q_cls(q_cls), .i_q_pop(q_pop)
    );

    // back: witness loop, one word at a time
    mrpt_back #(.W(VALUE_BITS), .NUM_WITNESSES(NUM_WITNESSES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_n(q_n),
        .i_q_cls(q_cls), .o_q_pop(q_pop), .o_valid(o_valid), .o_is_prime(o_is_prime)
    );
endmodule
`default_nettype wire

/* rtl/mrpt_checker.sv */
// port-level checker for the primality test core
`default_nettype none
module mrpt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);
    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result strobe right after reset");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy) else $error("busy after reset");
    a_busy_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !busy) else $error("busy rose without a word taken");
endmodule
bind miller_rabin_prime_test_core mrpt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_valid(o_valid)
);
`default_nettype wire

/* sim/tb_miller_rabin_prime_test_core.sv */
// testbench for the miller-rabin primality test core
`default_nettype none
module tb_miller_rabin_prime_test_core
    import mrpt_pkg::*;
();

    localparam int unsigned VBITS = 63;
    localparam int unsigned NWIT = 12;
    localparam int unsigned MAX_GAP = 18;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [VBITS-1:0] i_candidate;
    logic             o_valid;
    logic             o_is_prime;

    // verdicts still owed by the core, oldest first
    bit               pending_verdicts[$];
    int unsigned      mismatch_count;
    bit               unexpected_seen;

    miller_rabin_prime_test_core #(
        .NUM_WITNESSES(NWIT),
        .VALUE_BITS(VBITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_candidate(i_candidate),
        .o_valid(o_valid),
        .o_is_prime(o_is_prime)
    );

    // clock: period of 10
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // double-width product reduced mod m
    function automatic logic [63:0] mul_mod_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [63:0] pow_mod_m(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) acc = mul_mod_m(acc, b, m);
            b = mul_mod_m(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // one witness round, n greater than the base
    function automatic bit strong_probable_prime(logic [63:0] base, logic [63:0] n);
        logic [63:0] chain[65];
        logic [63:0] odd;
        int unsigned halvings;
        odd = n - 1;
        halvings = 0;
        while (odd[0] == 1'b0 && halvings < 64) begin
            odd = odd >> 1;
            halvings++;
        end
        chain[halvings] = pow_mod_m(base, odd, n);
        for (int k = halvings; k > 0; k--)
            chain[k-1] = mul_mod_m(chain[k], chain[k], n);
        if (chain[0] != 64'd1) return 1'b0;
        for (int k = 1; k <= halvings; k++) begin
            if (chain[k] != 64'd1) begin
                if (chain[k] != n - 1) return 1'b0;
                break;
            end
        end
        return 1'b1;
    endfunction

    // verdict the core should give for one candidate
    function automatic bit primality_verdict(logic [VBITS-1:0] cand);
        logic [63:0] n;
        logic [63:0] base;
        n = {{(64-VBITS){1'b0}}, cand};
        for (int i = 0; i < NWIT && i < WIT_TABLE_SIZE; i++) begin
            base = {58'd0, witness(i[WIT_IDX_BITS-1:0])};
            if (base == n) return 1'b1;
            if (base > n) return 1'b0;
            if (!strong_probable_prime(base, n)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // result checker: every strobed word against the oldest verdict
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_verdicts.size() == 0) begin
                unexpected_seen = 1'b1;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: is_prime=%0b", o_is_prime);
            end else begin
                bit want;
                want = pending_verdicts.pop_front();
                if (o_is_prime !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("is_prime mismatch: expected %0b actual %0b",
                                 want, o_is_prime);
                end
            end
        end
    end

    // send one word, after a random gap if allowed, and wait until accepted; start stays high
    // after the accepting edge so that a word with no gap follows at once
    task automatic send_candidate(logic [VBITS-1:0] cand, bit allow_gap = 1'b1);
        int unsigned gap;
        gap = allow_gap ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_candidate <= cand;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_verdicts = {pending_verdicts, primality_verdict(cand)};
    endtask

    task automatic drain_verdicts();
        start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // smallest values, every witness, and 4, 38 and 41
    task automatic test_small_values();
        send_candidate(63'd0);
        send_candidate(63'd1);
        for (int i = 0; i < NWIT; i++)
            send_candidate(63'(witness(i[WIT_IDX_BITS-1:0])), i[0]);
        send_candidate(63'd4);
        send_candidate(63'd38);
        send_candidate(63'd41);
    endtask

    // largest values and known hard cases
    task automatic test_wide_values();
        send_candidate({VBITS{1'b1}});
        send_candidate(63'h7FFF_FFFF_FFFF_FFE7);   // largest 63-bit prime
        send_candidate(63'd3215031751);            // strong pseudoprime to 2,3,5,7
        send_candidate(63'd3825123056546413051);   // strong pseudoprime to bases through 23
        send_candidate(63'd2305843009213693951);   // mersenne prime
        send_candidate(63'h5555_5555_5555_5555);
        send_candidate(63'h2AAA_AAAA_AAAA_AAAA);
        send_candidate(63'd561);
    endtask

    // random words, mostly small since the core is slow on wide ones
    task automatic test_random_values(int unsigned count);
        logic [VBITS-1:0] cand;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(3, 0))
                0: cand = 63'($urandom_range(200, 0));
                1: cand = 63'($urandom) | 63'd1;
                2: cand = 63'($urandom);
                default: cand = 63'({$urandom, $urandom} | 64'd1);
            endcase
            if (k == count / 2) drain_verdicts();   // sender pauses until all words are back
            send_candidate(cand, ($urandom_range(3, 0) != 0) && (k % 20 < 15));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_candidate = '0;
        mismatch_count = 0;
        unexpected_seen = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_small_values();
        test_wide_values();
        test_random_values(75);
        drain_verdicts();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && !unexpected_seen)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #1000000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
